@@ hw/rtl/sdspi_pkg.sv @@
// Shared types and constants for the SD card SPI-mode start-up sequencer.
// Holds the request and result payloads, the sequencer state record and codes.
// No dependencies; every other RTL file of the block imports this package.
package sdspi_pkg;

    // Request kinds carried in the action field.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_RX    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BLEN_ARG       = 2'd0,
        CFG_OP_COND_LIMIT  = 2'd1,
        CFG_POLL_LIMIT     = 2'd2,
        CFG_WAKE_COUNT     = 2'd3
    } cfg_index_t;

    // Configuration reset values.
    localparam logic [31:0] BLEN_ARG_RST = 32'd512;
    localparam logic [11:0] OP_COND_LIMIT_RST = 12'd2000;
    localparam logic [7:0]  POLL_LIMIT_RST = 8'd16;
    localparam logic [7:0]  WAKE_COUNT_RST = 8'd20;

    // Byte values on the wire.
    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_START   = 8'h40;
    localparam logic [7:0] CMD_MASK    = 8'h3F;
    localparam logic [7:0] CMD0_CRC    = 8'h95;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [2:0] FRAME_LAST  = 3'd5;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAKE  = 3'd1,
        PH_FLUSH = 3'd2,
        PH_FRAME = 3'd3,
        PH_POLL  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    // Commands in the order they are issued.
    typedef enum logic [1:0] {
        CMD_GO_IDLE  = 2'd0,
        CMD_OP_COND  = 2'd1,
        CMD_CRC_ON   = 2'd2,
        CMD_SET_BLEN = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FAIL_NONE  = 3'd0,
        FAIL_CMD0  = 3'd1,
        FAIL_CMD1  = 3'd2,
        FAIL_CMD59 = 3'd3,
        FAIL_CMD16 = 3'd4
    } fail_t;

    // Command index sent in the first frame byte.
    function automatic logic [7:0] cmd_number(input command_t cmd);
        logic [7:0] num;
        unique case (cmd)
            CMD_GO_IDLE:  num = 8'd0;
            CMD_OP_COND:  num = 8'd1;
            CMD_CRC_ON:   num = 8'd59;
            CMD_SET_BLEN: num = 8'd16;
            default:      num = 8'd0;
        endcase
        return num;
    endfunction

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_low;
        logic       slow_clock;
        logic [1:0] status;
        logic [2:0] failed_step;
    } out_item_t;

    typedef struct packed {
        logic [31:0] blen_arg;
        logic [11:0] op_cond_retry_limit;
        logic [7:0]  response_poll_limit;
        logic [7:0]  wake_byte_count;
    } cfg_regs_t;

    typedef struct packed {
        phase_t      phase;
        command_t    cmd;
        logic [2:0]  frame_idx;
        logic [7:0]  poll_misses;
        logic [11:0] op_attempts;
        logic [7:0]  wake_sent;
        status_t     final_status;
        fail_t       fail_code;
    } seq_state_t;

endpackage

@@ hw/rtl/sdspi_step.sv @@
// Next-state and result logic of the start-up sequencer for one request.
// Purely combinational; the top level registers both state and result.
// Depends on sdspi_pkg.
module sdspi_step
    import sdspi_pkg::*;
(
    input  seq_state_t cur,
    input  cfg_regs_t  cfg,
    input  in_item_t   item,
    output seq_state_t nxt,
    output out_item_t  result
);

    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       busy;
    logic       hit;
    logic       ok;
    logic       do_answer;
    logic [7:0] frame_value;
    logic [2:0] frame_sel;
    logic [31:0] arg;

    // Frame byte for the current command; the command does not change while framing.
    always_comb
    begin
        arg = (cur.cmd == CMD_SET_BLEN) ? cfg.blen_arg : 32'd0;
        case (frame_sel)
            3'd0:    frame_value = CMD_START | (cmd_number(cur.cmd) & CMD_MASK);
            3'd1:    frame_value = arg[31:24];
            3'd2:    frame_value = arg[23:16];
            3'd3:    frame_value = arg[15:8];
            3'd4:    frame_value = arg[7:0];
            default: frame_value = (cur.cmd == CMD_GO_IDLE) ? CMD0_CRC : FILL_BYTE;
        endcase
    end

    // Response detection while polling.
    always_comb
    begin
        if (cur.cmd == CMD_GO_IDLE)
        begin
            hit = (item.rx_byte == R1_IDLE);
            ok  = 1'b1;
        end
        else
        begin
            hit = (item.rx_byte != FILL_BYTE);
            ok  = (item.rx_byte == R1_READY);
        end
        if (!hit)
        begin
            ok = 1'b0;
        end
        do_answer = hit || (cur.poll_misses >= cfg.response_poll_limit);
    end

    // Phase sequencing for one exchange.
    always_comb
    begin
        nxt       = cur;
        tx_valid  = 1'b0;
        tx_byte   = FILL_BYTE;
        cs_low    = 1'b0;
        frame_sel = 3'd0;

        if (item.action == ACT_START)
        begin
            nxt.final_status = ST_BUSY;
            nxt.fail_code    = FAIL_NONE;
            nxt.op_attempts  = '0;
            nxt.wake_sent    = '0;
            tx_valid         = 1'b1;
            if (cfg.wake_byte_count != 8'd0)
            begin
                nxt.phase     = PH_WAKE;
                nxt.wake_sent = 8'd1;
            end
            else
            begin
                nxt.phase       = PH_FLUSH;
                nxt.cmd         = CMD_GO_IDLE;
                nxt.frame_idx   = '0;
                nxt.poll_misses = '0;
            end
        end
        else
        begin
            unique case (cur.phase)
                PH_WAKE:
                begin
                    tx_valid = 1'b1;
                    if (cur.wake_sent < cfg.wake_byte_count)
                    begin
                        nxt.wake_sent = cur.wake_sent + 8'd1;
                    end
                    else
                    begin
                        nxt.phase       = PH_FLUSH;
                        nxt.cmd         = CMD_GO_IDLE;
                        nxt.frame_idx   = '0;
                        nxt.poll_misses = '0;
                    end
                end
                PH_FLUSH:
                begin
                    nxt.phase     = PH_FRAME;
                    nxt.frame_idx = '0;
                    frame_sel     = 3'd0;
                    tx_valid      = 1'b1;
                    tx_byte       = frame_value;
                    cs_low        = 1'b1;
                end
                PH_FRAME:
                begin
                    tx_valid = 1'b1;
                    cs_low   = 1'b1;
                    if (cur.frame_idx < FRAME_LAST)
                    begin
                        nxt.frame_idx = cur.frame_idx + 3'd1;
                        frame_sel     = cur.frame_idx + 3'd1;
                        tx_byte       = frame_value;
                    end
                    else
                    begin
                        nxt.phase       = PH_POLL;
                        nxt.poll_misses = '0;
                    end
                end
                PH_POLL:
                begin
                    if (do_answer)
                    begin
                        // Default to a flush of the following command.
                        tx_valid        = 1'b1;
                        nxt.phase       = PH_FLUSH;
                        nxt.frame_idx   = '0;
                        nxt.poll_misses = '0;
                        case (cur.cmd)
                            CMD_GO_IDLE:
                            begin
                                if (ok)
                                begin
                                    nxt.op_attempts = '0;
                                    nxt.cmd         = CMD_OP_COND;
                                end
                                else
                                begin
                                    nxt.fail_code = FAIL_CMD0;
                                end
                            end
                            CMD_OP_COND:
                            begin
                                if (ok)
                                begin
                                    nxt.cmd = CMD_CRC_ON;
                                end
                                else if (cur.op_attempts >= cfg.op_cond_retry_limit)
                                begin
                                    nxt.fail_code = FAIL_CMD1;
                                end
                                else
                                begin
                                    nxt.op_attempts = cur.op_attempts + 12'd1;
                                    nxt.cmd         = CMD_OP_COND;
                                end
                            end
                            CMD_CRC_ON:
                            begin
                                if (ok)
                                begin
                                    nxt.cmd = CMD_SET_BLEN;
                                end
                                else
                                begin
                                    nxt.fail_code = FAIL_CMD59;
                                end
                            end
                            default:
                            begin
                                nxt.fail_code = ok ? FAIL_NONE : FAIL_CMD16;
                            end
                        endcase

                        // Finishing: restore the untouched counters and stop.
                        if ((cur.cmd == CMD_SET_BLEN) || (nxt.fail_code != FAIL_NONE))
                        begin
                            nxt.phase        = PH_DONE;
                            nxt.frame_idx    = cur.frame_idx;
                            nxt.poll_misses  = cur.poll_misses;
                            nxt.final_status = (nxt.fail_code == FAIL_NONE) ? ST_OK : ST_FAIL;
                            tx_valid         = 1'b0;
                        end
                    end
                    else
                    begin
                        nxt.poll_misses = cur.poll_misses + 8'd1;
                        tx_valid        = 1'b1;
                        cs_low          = 1'b1;
                    end
                end
                default:
                begin
                    tx_valid = 1'b0;
                end
            endcase
        end
    end

    // Status fields follow the state after this exchange.
    always_comb
    begin
        busy               = (nxt.phase != PH_DONE) && (nxt.phase != PH_IDLE);
        result.tx_valid    = tx_valid;
        result.tx_byte     = tx_byte;
        result.cs_low      = cs_low;
        result.slow_clock  = busy || (nxt.final_status == ST_FAIL);
        result.status      = busy ? ST_BUSY : nxt.final_status;
        result.failed_step = busy ? FAIL_NONE : nxt.fail_code;
    end

endmodule

@@ hw/rtl/sd_spi_init_sequencer.sv @@
// SD card SPI-mode start-up sequencer: top level with request, result and
// configuration ports. An accepted request passes through an input register, then
// the step logic into the result register, before its result appears on the result port.
// Throughput is one request per cycle while out_stall is low; the sequencer state
// updates in the same cycle that a result is registered. Reset clears all control
// state and loads the configuration defaults; no clearing pass is needed.
module sd_spi_init_sequencer
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic       in_vld_reg;
    in_item_t   in_item_reg;
    logic       out_vld_reg;
    out_item_t  out_item_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_item_t  step_result;
    cfg_regs_t  cfg_reg;
    logic       process;

    // Handshake: a held request is processed once the result register is free.
    assign process   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !process;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blen_arg            <= BLEN_ARG_RST;
            cfg_reg.op_cond_retry_limit <= OP_COND_LIMIT_RST;
            cfg_reg.response_poll_limit <= POLL_LIMIT_RST;
            cfg_reg.wake_byte_count     <= WAKE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BLEN_ARG:      cfg_reg.blen_arg            <= cfg_data;
                CFG_OP_COND_LIMIT: cfg_reg.op_cond_retry_limit <= cfg_data[11:0];
                CFG_POLL_LIMIT:    cfg_reg.response_poll_limit <= cfg_data[7:0];
                CFG_WAKE_COUNT:    cfg_reg.wake_byte_count     <= cfg_data[7:0];
                default:           cfg_reg.blen_arg            <= cfg_reg.blen_arg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    sdspi_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .item   (in_item_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    // Sequencer state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.cmd          <= CMD_GO_IDLE;
            state_reg.frame_idx    <= '0;
            state_reg.poll_misses  <= '0;
            state_reg.op_attempts  <= '0;
            state_reg.wake_sent    <= '0;
            state_reg.final_status <= ST_BUSY;
            state_reg.fail_code    <= FAIL_NONE;
            out_vld_reg            <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                state_reg   <= state_next;
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_item_reg <= step_result;
        end
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the SD card SPI-mode start-up sequencer.
// Walks a directed table of requests and register writes, then random card sessions,
// and checks every result against an in-bench prediction. Depends on sdspi_pkg and the RTL.
module tb;
    import sdspi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1850;
    localparam int IDLE_PCT = 19;
    localparam int HOLD_LEN = 80;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic       act;
        logic [7:0] rx;
        cfg_index_t idx;
        logic [31:0] value;
        bit         typed;
        out_item_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predicted sequencer state and configuration.
    phase_t      seq_phase;
    command_t    seq_cmd;
    logic [2:0]  frame_idx;
    logic [7:0]  poll_misses;
    logic [11:0] op_attempts;
    logic [7:0]  wake_sent;
    status_t     final_st;
    fail_t       fail_code;
    logic [31:0] blk_len;
    logic [11:0] op_limit;
    logic [7:0]  poll_limit;
    logic [7:0]  wake_count;

    // Card behavior for the current random session, in percent.
    int miss_pct;
    int busy_pct;
    int err_pct;

    out_item_t   expected_results[$];
    out_item_t   head;
    stim_row_t   plan[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_cfg = 0;
    int          n_ok = 0;
    int          n_failed = 0;
    int          hold_cycles = 0;
    bit          no_idle = 0;

    sd_spi_init_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Builds a result record from its fields.
    function automatic out_item_t result_of(logic v, logic [7:0] b, logic cs, logic slow,
                                            status_t st, fail_t f);
        out_item_t r;
        r.tx_valid = v;
        r.tx_byte = b;
        r.cs_low = cs;
        r.slow_clock = slow;
        r.status = st;
        r.failed_step = f;
        return r;
    endfunction

    function automatic void reset_model();
        blk_len = BLEN_ARG_RST;
        op_limit = OP_COND_LIMIT_RST;
        poll_limit = POLL_LIMIT_RST;
        wake_count = WAKE_COUNT_RST;
        seq_phase = PH_IDLE;
        seq_cmd = CMD_GO_IDLE;
        frame_idx = '0;
        poll_misses = '0;
        op_attempts = '0;
        wake_sent = '0;
        final_st = ST_BUSY;
        fail_code = FAIL_NONE;
    endfunction

    function automatic void apply_cfg(cfg_index_t idx, logic [31:0] value);
        case (idx)
            CFG_BLEN_ARG:      blk_len = value;
            CFG_OP_COND_LIMIT: op_limit = value[11:0];
            CFG_POLL_LIMIT:    poll_limit = value[7:0];
            CFG_WAKE_COUNT:    wake_count = value[7:0];
            default: ;
        endcase
    endfunction

    // Result fields that follow from the phase after a step.
    function automatic out_item_t make_result(logic v, logic [7:0] b, logic cs);
        logic busy;
        busy = (seq_phase != PH_DONE) && (seq_phase != PH_IDLE);
        return result_of(v, b, cs, busy || (final_st == ST_FAIL),
                         busy ? ST_BUSY : final_st, busy ? FAIL_NONE : fail_code);
    endfunction

    // Byte idx of the six-byte frame of the current command.
    function automatic logic [7:0] frame_value(logic [2:0] idx);
        logic [7:0]  opcode;
        logic [31:0] arg;
        logic [7:0]  b;
        case (seq_cmd)
            CMD_GO_IDLE:  opcode = 8'd0;
            CMD_OP_COND:  opcode = 8'd1;
            CMD_CRC_ON:   opcode = 8'd59;
            default:      opcode = 8'd16;
        endcase
        arg = (seq_cmd == CMD_SET_BLEN) ? blk_len : 32'd0;
        if (idx == 3'd0)
            b = CMD_START | (opcode & CMD_MASK);
        else if (idx <= 3'd4)
            b = 8'(arg >> ((4 - int'(idx)) * 8));
        else
            b = (seq_cmd == CMD_GO_IDLE) ? CMD0_CRC : FILL_BYTE;
        return b;
    endfunction

    function automatic void start_command(command_t c);
        seq_cmd = c;
        frame_idx = '0;
        poll_misses = '0;
        seq_phase = PH_FLUSH;
    endfunction

    function automatic void finish_seq(status_t st, fail_t f);
        seq_phase = PH_DONE;
        final_st = st;
        fail_code = f;
    endfunction

    // Moves on after a command answered or timed out.
    function automatic void take_answer(bit ok);
        case (seq_cmd)
            CMD_GO_IDLE:
                if (ok)
                begin
                    op_attempts = '0;
                    start_command(CMD_OP_COND);
                end
                else
                    finish_seq(ST_FAIL, FAIL_CMD0);
            CMD_OP_COND:
                if (ok)
                    start_command(CMD_CRC_ON);
                else if (op_attempts >= op_limit)
                    finish_seq(ST_FAIL, FAIL_CMD1);
                else
                begin
                    op_attempts = op_attempts + 12'd1;
                    start_command(CMD_OP_COND);
                end
            CMD_CRC_ON:
                if (ok)
                    start_command(CMD_SET_BLEN);
                else
                    finish_seq(ST_FAIL, FAIL_CMD59);
            default:
                if (ok)
                    finish_seq(ST_OK, FAIL_NONE);
                else
                    finish_seq(ST_FAIL, FAIL_CMD16);
        endcase
    endfunction

    // Advances the predicted sequencer by one request and returns its result.
    function automatic out_item_t sequencer_next(logic act, logic [7:0] rx);
        logic       v;
        logic [7:0] b;
        logic       cs;
        bit         hit;
        v = 1'b0;
        b = FILL_BYTE;
        cs = 1'b0;
        if (act == ACT_START)
        begin
            final_st = ST_BUSY;
            fail_code = FAIL_NONE;
            op_attempts = '0;
            wake_sent = '0;
            v = 1'b1;
            if (wake_count != 8'd0)
            begin
                seq_phase = PH_WAKE;
                wake_sent = 8'd1;
            end
            else
                start_command(CMD_GO_IDLE);
        end
        else
        begin
            case (seq_phase)
                PH_WAKE:
                begin
                    v = 1'b1;
                    if (wake_sent < wake_count)
                        wake_sent = wake_sent + 8'd1;
                    else
                        start_command(CMD_GO_IDLE);
                end
                PH_FLUSH:
                begin
                    seq_phase = PH_FRAME;
                    frame_idx = '0;
                    v = 1'b1;
                    b = frame_value(3'd0);
                    cs = 1'b1;
                end
                PH_FRAME:
                begin
                    v = 1'b1;
                    cs = 1'b1;
                    if (frame_idx < FRAME_LAST)
                    begin
                        frame_idx = frame_idx + 3'd1;
                        b = frame_value(frame_idx);
                    end
                    else
                    begin
                        seq_phase = PH_POLL;
                        poll_misses = '0;
                    end
                end
                PH_POLL:
                begin
                    hit = (seq_cmd == CMD_GO_IDLE) ? (rx == R1_IDLE) : (rx != FILL_BYTE);
                    if (hit || poll_misses >= poll_limit)
                    begin
                        // A response or a timeout ends the poll; next is a flush or the end.
                        take_answer(hit && ((seq_cmd == CMD_GO_IDLE) || (rx == R1_READY)));
                        v = (seq_phase != PH_DONE);
                    end
                    else
                    begin
                        poll_misses = poll_misses + 8'd1;
                        v = 1'b1;
                        cs = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return make_result(v, b, cs);
    endfunction

    // Byte a card would return for the exchange just predicted.
    function automatic logic [7:0] card_reply();
        logic [7:0] r;
        r = 8'($urandom);
        if (seq_phase == PH_POLL)
        begin
            if ($urandom_range(99) < miss_pct)
            begin
                // CMD0 ignores any byte but the idle answer; the rest only see 0xFF as silence.
                if (seq_cmd != CMD_GO_IDLE || $urandom_range(1) == 0 || r == R1_IDLE)
                    r = FILL_BYTE;
            end
            else if (seq_cmd == CMD_GO_IDLE)
                r = R1_IDLE;
            else if (seq_cmd == CMD_OP_COND && $urandom_range(99) < busy_pct)
                r = R1_IDLE;
            else if ($urandom_range(99) < err_pct)
                r = 8'($urandom_range(1, 254));
            else
                r = R1_READY;
        end
        return r;
    endfunction

    // Register values, weighted toward the extremes.
    function automatic logic [31:0] pick_value(cfg_index_t idx);
        int roll;
        logic [31:0] v;
        roll = $urandom_range(99);
        case (idx)
            CFG_BLEN_ARG:
                v = (roll < 25) ? 32'd0 : (roll < 50) ? 32'hFFFF_FFFF :
                    (roll < 60) ? 32'd512 : $urandom;
            CFG_OP_COND_LIMIT:
                v = (roll < 25) ? 32'd0 : (roll < 40) ? 32'd1 : (roll < 45) ? 32'd4095 :
                    (roll < 50) ? 32'd2000 : $urandom_range(2, 8);
            CFG_POLL_LIMIT:
                v = (roll < 25) ? 32'd0 : (roll < 40) ? 32'd1 : (roll < 50) ? 32'd255 :
                    $urandom_range(2, 20);
            default:
                v = (roll < 15) ? 32'd0 : (roll < 35) ? 32'd1 : (roll < 40) ? 32'd255 :
                    $urandom_range(2, 12);
        endcase
        // Bits above the register width are don't-care; exercise them too.
        if (idx == CFG_OP_COND_LIMIT)
            v = v | ($urandom & 32'hFFFF_F000);
        else if (idx != CFG_BLEN_ARG)
            v = v | ($urandom & 32'hFFFF_FF00);
        return v;
    endfunction

    // Stops offering requests until every predicted result has been seen.
    task automatic wait_all_results();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        wait_all_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, value);
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offers one request, waits for it to be taken and queues its result.
    task automatic send_req(logic act, logic [7:0] rx, bit typed, out_item_t want);
        out_item_t pred;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.action = act;
        in_data.rx_byte = rx;
        do
            @(posedge clk);
        while (in_stall);
        pred = sequencer_next(act, rx);
        expected_results.push_back(typed ? want : pred);
        n_items++;
        @(negedge clk);
    endtask

    function automatic void plan_req(logic act, logic [7:0] rx, bit typed, out_item_t want);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.act = act;
        row.rx = rx;
        row.idx = CFG_BLEN_ARG;
        row.value = '0;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(cfg_index_t idx, logic [31:0] value);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.act = ACT_RX;
        row.rx = '0;
        row.idx = idx;
        row.value = value;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    // Receiver: random stalls, one long hold-off on request, quiet stretch when asked.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
                out_stall = !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_checked++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d arrived with nothing expected: %p", n_checked, out_data);
            end
            else
            begin
                head = expected_results.pop_front();
                if (out_data.tx_valid !== head.tx_valid || out_data.tx_byte !== head.tx_byte ||
                    out_data.cs_low !== head.cs_low || out_data.slow_clock !== head.slow_clock ||
                    out_data.status !== head.status || out_data.failed_step !== head.failed_step)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected valid=%0b byte=%02h cs=%0b slow=%0b",
                                 n_checked, head.tx_valid, head.tx_byte, head.cs_low,
                                 head.slow_clock, " st=%0d step=%0d,", head.status,
                                 head.failed_step, " got valid=%0b byte=%02h cs=%0b",
                                 out_data.tx_valid, out_data.tx_byte, out_data.cs_low,
                                 " slow=%0b st=%0d step=%0d", out_data.slow_clock,
                                 out_data.status, out_data.failed_step);
                end
            end
        end
    end

    // Main stimulus.
    initial
    begin
        bit hold_done;
        bit pause_done;
        bit first_cfg;
        int roll;
        int extra;
        hold_done = 1'b0;
        pause_done = 1'b0;
        first_cfg = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BLEN_ARG;
        cfg_data = '0;
        miss_pct = 0;
        busy_pct = 0;
        err_pct = 0;
        reset_model();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a receive before any start, zero wake count straight into CMD0,
        // a CMD0 timeout with no poll slack, the finished result repeating, then a
        // maximal wake count with a restart in the middle of the wake-up bytes.
        plan_req(ACT_RX, 8'h00, 1'b1, result_of(1'b0, FILL_BYTE, 1'b0, 1'b0, ST_BUSY, FAIL_NONE));
        plan_cfg(CFG_WAKE_COUNT, 32'd0);
        plan_cfg(CFG_POLL_LIMIT, 32'd0);
        plan_req(ACT_START, 8'hFF, 1'b1,
                 result_of(1'b1, FILL_BYTE, 1'b0, 1'b1, ST_BUSY, FAIL_NONE));
        plan_req(ACT_RX, 8'hFF, 1'b1, result_of(1'b1, 8'h40, 1'b1, 1'b1, ST_BUSY, FAIL_NONE));
        plan_req(ACT_RX, 8'h00, 1'b0, '0);
        plan_req(ACT_RX, 8'h5A, 1'b0, '0);
        plan_req(ACT_RX, 8'hA5, 1'b0, '0);
        plan_req(ACT_RX, 8'h01, 1'b0, '0);
        plan_req(ACT_RX, 8'hFF, 1'b1, result_of(1'b1, 8'h95, 1'b1, 1'b1, ST_BUSY, FAIL_NONE));
        plan_req(ACT_RX, 8'hFF, 1'b0, '0);
        plan_req(ACT_RX, 8'h00, 1'b1, result_of(1'b0, FILL_BYTE, 1'b0, 1'b1, ST_FAIL, FAIL_CMD0));
        plan_req(ACT_RX, 8'h01, 1'b1, result_of(1'b0, FILL_BYTE, 1'b0, 1'b1, ST_FAIL, FAIL_CMD0));
        plan_cfg(CFG_WAKE_COUNT, 32'd255);
        plan_cfg(CFG_OP_COND_LIMIT, 32'd4095);
        plan_cfg(CFG_BLEN_ARG, 32'hFFFF_FFFF);
        plan_req(ACT_START, 8'h80, 1'b1,
                 result_of(1'b1, FILL_BYTE, 1'b0, 1'b1, ST_BUSY, FAIL_NONE));
        plan_req(ACT_RX, 8'h7F, 1'b0, '0);
        plan_req(ACT_START, 8'hAA, 1'b0, '0);
        plan_req(ACT_RX, 8'h55, 1'b0, '0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].value);
            else
                send_req(plan[i].act, plan[i].rx, plan[i].typed, plan[i].want);
        end

        // Random card sessions until the request budget is spent.
        while (n_items < ITEM_TARGET)
        begin
            if (first_cfg || $urandom_range(99) < 25)
            begin
                if (first_cfg)
                begin
                    write_reg(CFG_BLEN_ARG, pick_value(CFG_BLEN_ARG));
                    write_reg(CFG_OP_COND_LIMIT, pick_value(CFG_OP_COND_LIMIT));
                    write_reg(CFG_POLL_LIMIT, pick_value(CFG_POLL_LIMIT));
                    write_reg(CFG_WAKE_COUNT, pick_value(CFG_WAKE_COUNT));
                    first_cfg = 1'b0;
                end
                else
                begin
                    extra = $urandom_range(1, 2);
                    repeat (extra)
                    begin
                        roll = $urandom_range(3);
                        write_reg(cfg_index_t'(roll), pick_value(cfg_index_t'(roll)));
                    end
                end
            end

            roll = $urandom_range(3);
            miss_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : (roll == 2) ? 40 : 80;
            busy_pct = $urandom_range(0, 70);
            err_pct = ($urandom_range(3) == 0) ? 50 : ($urandom_range(1) == 0) ? 10 : 0;

            send_req(ACT_START, 8'($urandom), 1'b0, '0);
            while (seq_phase != PH_DONE && n_items < ITEM_TARGET)
            begin
                // Long receiver hold-off while requests keep coming, so the block backs up.
                if (!hold_done && n_items >= 300)
                begin
                    hold_cycles = HOLD_LEN;
                    hold_done = 1'b1;
                end
                if (!pause_done && n_items >= 900)
                begin
                    wait_all_results();
                    pause_done = 1'b1;
                end
                no_idle = (n_items >= 1000) && (n_items < 1250);

                roll = $urandom_range(999);
                if (roll < 8)
                    send_req(ACT_START, 8'($urandom), 1'b0, '0);
                else if (roll < 20)
                    send_req(ACT_RX, 8'($urandom), 1'b0, '0);
                else if (roll < 25)
                begin
                    // Mid-session register change, may drop a limit below its count.
                    extra = $urandom_range(3);
                    write_reg(cfg_index_t'(extra), pick_value(cfg_index_t'(extra)));
                end
                else
                    send_req(ACT_RX, card_reply(), 1'b0, '0);
            end

            if (seq_phase == PH_DONE)
            begin
                if (final_st == ST_OK)
                    n_ok++;
                else
                    n_failed++;
                extra = $urandom_range(0, 2);
                repeat (extra)
                    send_req(ACT_RX, 8'($urandom), 1'b0, '0);
            end
        end

        // Drain, with a bound, then give stray results time to show up.
        in_valid = 1'b0;
        no_idle = 1'b0;
        for (int i = 0; i < 5000 && expected_results.size() != 0; i++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            errors += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Sent %0d requests and %0d register writes; checked %0d results.",
                 n_items, n_cfg, n_checked);
        $display("Sessions reaching the end: %0d initialized, %0d failed; %0d mismatches.",
                 n_ok, n_failed, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
